// ===== sv/cned_pkg.sv =====
// ----------------------------------------------------------------------------
// cned_pkg: shared definitions for the circular nearest equal distance core
// Sizes, field widths, command codes, the request and result structs between
// the top level and the scan sequencer, and the ring address steppers.
// ----------------------------------------------------------------------------
package cned_pkg;

  // Store geometry.
  localparam int RING_DEPTH = 1024;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int LEN_W      = $clog2(RING_DEPTH + 1);

  // Fixed field widths of the ports.
  localparam int CFG_W      = 11;
  localparam int POS_W      = 10;
  localparam int VAL_W      = 32;
  localparam int DIST_W     = 10;
  localparam int IN_DATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((DIST_W + 7) / 8) * 8;

  // Common width for length and position compares.
  localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  // Common width for the value word before it is cut to the store width.
  localparam int VEXT_W = (VALUE_BITS > VAL_W) ? VALUE_BITS : VAL_W;

  // Command codes carried in the input tuser.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Query request from the top level to the scan sequencer.
  typedef struct packed {
    logic              start;
    logic              in_range;
    logic [ADDR_W-1:0] pos;
    logic [LEN_W-1:0]  len;
  } scan_req_t;

  // Query result from the scan sequencer.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [LEN_W-1:0] distance;
  } scan_res_t;

  // One step forward around a ring of the given length.
  function automatic logic [ADDR_W-1:0] step_fwd(input logic [ADDR_W-1:0] a,
                                                 input logic [LEN_W-1:0]  len);
    logic [LEN_W-1:0] inc;
    inc = LEN_W'(a) + LEN_W'(1);
    if (inc == len) begin
      inc = '0;
    end
    return inc[ADDR_W-1:0];
  endfunction

  // One step backward around a ring of the given length.
  function automatic logic [ADDR_W-1:0] step_bwd(input logic [ADDR_W-1:0] a,
                                                 input logic [LEN_W-1:0]  len);
    logic [LEN_W-1:0] dec;
    if (a == '0) begin
      dec = len - LEN_W'(1);
    end else begin
      dec = LEN_W'(a) - LEN_W'(1);
    end
    return dec[ADDR_W-1:0];
  endfunction

endpackage

// ===== sv/cned_store.sv =====
// ----------------------------------------------------------------------------
// cned_store: ring value memory
// One write port and two read ports with registered read data. The contents
// are not cleared; entries are defined once they are loaded.
// ----------------------------------------------------------------------------
module cned_store (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [cned_pkg::ADDR_W-1:0]     wr_addr,
  input  logic [cned_pkg::VALUE_BITS-1:0] wr_data,
  input  logic [cned_pkg::ADDR_W-1:0]     rd_addr_a,
  input  logic [cned_pkg::ADDR_W-1:0]     rd_addr_b,
  output logic [cned_pkg::VALUE_BITS-1:0] rd_data_a,
  output logic [cned_pkg::VALUE_BITS-1:0] rd_data_b
);
  import cned_pkg::*;

  logic [VALUE_BITS-1:0] mem [RING_DEPTH];
  logic [VALUE_BITS-1:0] rd_data_a_r;
  logic [VALUE_BITS-1:0] rd_data_b_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two registered read ports, read every cycle.
  always_ff @(posedge clk) begin
    rd_data_a_r <= mem[rd_addr_a];
    rd_data_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// ===== sv/cned_scan.sv =====
// ----------------------------------------------------------------------------
// cned_scan: outward scan sequencer
// Reads the target word, then steps one distance per cycle in both directions
// around the ring, comparing both read words against the target.
// ----------------------------------------------------------------------------
module cned_scan (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cned_pkg::scan_req_t             req,
  input  logic                            res_ready,
  output cned_pkg::scan_res_t             res,
  output logic                            idle,
  output logic [cned_pkg::ADDR_W-1:0]     rd_addr_a,
  output logic [cned_pkg::ADDR_W-1:0]     rd_addr_b,
  input  logic [cned_pkg::VALUE_BITS-1:0] rd_data_a,
  input  logic [cned_pkg::VALUE_BITS-1:0] rd_data_b
);
  import cned_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TGT  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            st_r,     st_nxt;
  logic [LEN_W-1:0]      len_r,    len_nxt;
  logic [LEN_W-1:0]      half_r,   half_nxt;
  logic [LEN_W-1:0]      d_r,      d_nxt;
  logic [LEN_W-1:0]      cmp_d_r,  cmp_d_nxt;
  logic [ADDR_W-1:0]     fwd_r,    fwd_nxt;
  logic [ADDR_W-1:0]     bwd_r,    bwd_nxt;
  logic [VALUE_BITS-1:0] target_r, target_nxt;
  logic                  found_r,  found_nxt;
  logic [LEN_W-1:0]      dist_r,   dist_nxt;
  logic                  hit;

  // Shared compare of both read words against the target.
  assign hit = (rd_data_a == target_r) || (rd_data_b == target_r);

  // Sequencer.
  always_comb begin
    st_nxt     = st_r;
    len_nxt    = len_r;
    half_nxt   = half_r;
    d_nxt      = d_r;
    cmp_d_nxt  = cmp_d_r;
    fwd_nxt    = fwd_r;
    bwd_nxt    = bwd_r;
    target_nxt = target_r;
    found_nxt  = found_r;
    dist_nxt   = dist_r;
    rd_addr_a  = fwd_r;
    rd_addr_b  = bwd_r;
    case (st_r)
      S_IDLE: begin
        rd_addr_a = req.pos;
        if (req.start) begin
          len_nxt  = req.len;
          half_nxt = req.len >> 1;
          if (req.in_range && ((req.len >> 1) != '0)) begin
            fwd_nxt = step_fwd(req.pos, req.len);
            bwd_nxt = step_bwd(req.pos, req.len);
            d_nxt   = LEN_W'(1);
            st_nxt  = S_TGT;
          end else begin
            found_nxt = 1'b0;
            dist_nxt  = '0;
            st_nxt    = S_DONE;
          end
        end
      end
      S_TGT: begin
        // Target word arrives; the first pair of reads goes out.
        target_nxt = rd_data_a;
        cmp_d_nxt  = d_r;
        d_nxt      = d_r + LEN_W'(1);
        fwd_nxt    = step_fwd(fwd_r, len_r);
        bwd_nxt    = step_bwd(bwd_r, len_r);
        st_nxt     = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          found_nxt = 1'b1;
          dist_nxt  = cmp_d_r;
          st_nxt    = S_DONE;
        end else if (cmp_d_r == half_r) begin
          found_nxt = 1'b0;
          dist_nxt  = '0;
          st_nxt    = S_DONE;
        end else begin
          cmp_d_nxt = d_r;
          d_nxt     = d_r + LEN_W'(1);
          fwd_nxt   = step_fwd(fwd_r, len_r);
          bwd_nxt   = step_bwd(bwd_r, len_r);
        end
      end
      S_DONE: begin
        if (res_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // State register with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    half_r   <= half_nxt;
    d_r      <= d_nxt;
    cmp_d_r  <= cmp_d_nxt;
    fwd_r    <= fwd_nxt;
    bwd_r    <= bwd_nxt;
    target_r <= target_nxt;
    found_r  <= found_nxt;
    dist_r   <= dist_nxt;
  end

  assign idle         = (st_r == S_IDLE);
  assign res.valid    = (st_r == S_DONE);
  assign res.found    = found_r;
  assign res.distance = dist_r;

  // The compared distance stays within one to half the ring.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SCAN) |-> ((cmp_d_r != '0) && (cmp_d_r <= half_r)))
    else $error("scan distance out of range");

  // A found result carries a nonzero distance of at most half the ring.
  a_found_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.found) |-> ((res.distance != '0) && (res.distance <= half_r)))
    else $error("found result with bad distance");

  // The target read is always entered straight from idle on a start.
  a_tgt_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_TGT) |-> ($past(st_r) == S_IDLE && $past(req.start)))
    else $error("target read entered without start");

  // The issued distance runs one ahead of the compared distance.
  a_pipe_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SCAN) |-> (d_r == cmp_d_r + LEN_W'(1)))
    else $error("scan pipeline out of step");

endmodule

// ===== sv/circular_nearest_equal_distance_core.sv =====
// A query with no partner scans the whole half ring; one outside the ring or
// on a ring of length one goes to its result word without a scan.
// Load words are accepted while no query is in progress; a query holds off
// the input stream until its result is taken by the output register.
// Synchronous active-low reset clears control state and sets ring_length to 1.
// ----------------------------------------------------------------------------
// circular_nearest_equal_distance_core: nearest equal value on a ring
// Loads value words into the ring store and answers position queries with
// the smallest circular distance to another position holding the same value.
// ----------------------------------------------------------------------------
module circular_nearest_equal_distance_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration: ring_length.
  input  logic                              cfg_wr_en,
  input  logic [cned_pkg::CFG_W-1:0]        cfg_wr_data,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata: position [9:0], value [41:10], zero fill above.
  input  logic [cned_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: command [0].
  input  logic [0:0]                        in_tuser,
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: distance [9:0], zero fill above.
  output logic [cned_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: found [0].
  output logic [0:0]                        out_tuser
);
  import cned_pkg::*;

  logic [CFG_W-1:0]      ring_length_r;
  logic [CMP_W-1:0]      len_ext;
  logic [CMP_W-1:0]      pos_ext;
  logic [VEXT_W-1:0]     val_ext;
  logic [CMP_W-1:0]      dist_ext;
  logic                  in_fire;
  logic                  scan_idle;
  logic                  res_ready;
  logic                  wr_en;
  scan_req_t             req;
  scan_res_t             res;
  logic [ADDR_W-1:0]     rd_addr_a;
  logic [ADDR_W-1:0]     rd_addr_b;
  logic [VALUE_BITS-1:0] rd_data_a;
  logic [VALUE_BITS-1:0] rd_data_b;
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [DIST_W-1:0]     out_dist_r;

  // Ring length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_length_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      ring_length_r <= cfg_wr_data;
    end
  end

  // Effective length: zero reads as one, large values saturate to the depth.
  always_comb begin
    len_ext = CMP_W'(ring_length_r);
    if (len_ext == '0) begin
      len_ext = CMP_W'(1);
    end else if (len_ext > CMP_W'(RING_DEPTH)) begin
      len_ext = CMP_W'(RING_DEPTH);
    end
  end

  // Input word decode.
  assign pos_ext   = CMP_W'(in_tdata[POS_W-1:0]);
  assign val_ext   = VEXT_W'(in_tdata[POS_W+VAL_W-1:POS_W]);
  assign in_tready = scan_idle;
  assign in_fire   = in_tvalid && in_tready;

  // Loads write the store directly; positions outside the store are dropped.
  assign wr_en = in_fire && (in_tuser[0] == CMD_LOAD) && (pos_ext < CMP_W'(RING_DEPTH));

  // Query request to the scan sequencer.
  assign req.start    = in_fire && (in_tuser[0] == CMD_QUERY);
  assign req.in_range = (pos_ext < len_ext);
  assign req.pos      = pos_ext[ADDR_W-1:0];
  assign req.len      = len_ext[LEN_W-1:0];

  cned_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (pos_ext[ADDR_W-1:0]),
    .wr_data   (val_ext[VALUE_BITS-1:0]),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  cned_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .res_ready (res_ready),
    .res       (res),
    .idle      (scan_idle),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // Output register: takes a result when empty or being drained.
  assign res_ready = !out_valid_r || out_tready;
  assign dist_ext  = CMP_W'(res.distance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_found_r <= res.found;
      out_dist_r  <= dist_ext[DIST_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - DIST_W)'(0), out_dist_r};
  assign out_tuser  = out_found_r;

endmodule
